[rtl/lcpd_pkg.sv]
package lcpd_pkg;

  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 8;
  localparam int unsigned RawChunkDef = 64;

  localparam logic [7:0] MaxLengthRst = 8'd67;
  localparam logic [7:0] HidIdRst     = 8'd1;
  localparam logic [7:0] CdcIdRst     = 8'd2;
  localparam logic [7:0] DevIdRst     = 8'd3;

  localparam logic [7:0] SumGood     = 8'hFF;
  localparam logic [7:0] RawHeader   = 8'd3;
  localparam logic [7:0] MinLength   = 8'd2;
  localparam logic [7:0] IdOffset    = 8'd2;
  localparam logic [7:0] MinIdLength = 8'd3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RAW_MODE   = 3'd0,
    CFG_MAX_LENGTH = 3'd1,
    CFG_HID_ID     = 3'd2,
    CFG_CDC_ID     = 3'd3,
    CFG_DEV_ID     = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    DEST_HID  = 2'd0,
    DEST_CDC  = 2'd1,
    DEST_DEV  = 2'd2,
    DEST_DROP = 2'd3
  } dest_e;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_LENGTH   = 3'd1,
    ERR_NOBUF    = 3'd2,
    ERR_CHECKSUM = 3'd3,
    ERR_ID       = 3'd4
  } err_e;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] byte_value;
    logic [7:0] byte_index;
    logic       packet_end;
    logic [7:0] packet_length;
    dest_e      destination;
    err_e       error_code;
    logic       discarding;
  } result_t;

endpackage

[rtl/length_checksum_packet_deframer.sv]
// Length-prefixed packet deframer with an additive checksum. Each input beat
// (a received byte or a receive timeout) yields exactly one result beat that
// says where the byte lands in the packet buffer and, when a packet closes,
// its length, destination and error status. The whole per-byte update (sum,
// counters, id routing) is a single combinational step into the result
// register, so one beat is accepted every cycle, its result appears in the
// next cycle, and a stalled result register holds off input only while full.
// The user writes configuration through a plain write port only while idle;
// the block does not enforce it. Writing raw_mode abandons any open packet.
module length_checksum_packet_deframer
  import lcpd_pkg::*;
#(
  parameter int unsigned RAW_CHUNK = RawChunkDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,

  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,

  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                command_i,
  input  logic [7:0]          rx_byte_i,
  input  logic                more_pending_i,
  input  logic                buffer_available_i,

  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                byte_valid_o,
  output logic [7:0]          byte_value_o,
  output logic [7:0]          byte_index_o,
  output logic                packet_end_o,
  output logic [7:0]          packet_length_o,
  output logic [1:0]          destination_o,
  output logic [2:0]          error_code_o,
  output logic                discarding_o
);

  localparam logic [8:0] RawLimit = 9'(RAW_CHUNK) + 9'(RawHeader);

  logic       raw_mode_q, raw_mode_d;
  logic [7:0] max_length_q, max_length_d;
  logic [7:0] hid_id_q, hid_id_d;
  logic [7:0] cdc_id_q, cdc_id_d;
  logic [7:0] dev_id_q, dev_id_d;

  logic       packet_open_q, packet_open_d;
  logic       discard_q, discard_d;
  logic [7:0] bytes_rem_q, bytes_rem_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] wr_pos_q, wr_pos_d;
  logic [7:0] packet_id_q, packet_id_d;
  logic [7:0] total_len_q, total_len_d;

  logic    out_valid_q, out_valid_d;
  result_t res_q, res_d;
  logic    in_fire;

  logic [7:0] raw_pos;
  logic [7:0] raw_pos_inc;
  logic [7:0] sum_inc;
  logic [7:0] rem_dec;
  logic [7:0] id_value;
  logic       id_hit;
  dest_e      id_dest;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    raw_mode_d   = raw_mode_q;
    max_length_d = max_length_q;
    hid_id_d     = hid_id_q;
    cdc_id_d     = cdc_id_q;
    dev_id_d     = dev_id_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_RAW_MODE:   raw_mode_d   = cfg_data_i[0];
        CFG_MAX_LENGTH: max_length_d = cfg_data_i;
        CFG_HID_ID:     hid_id_d     = cfg_data_i;
        CFG_CDC_ID:     cdc_id_d     = cfg_data_i;
        CFG_DEV_ID:     dev_id_d     = cfg_data_i;
        default: ;
      endcase
    end
  end

  // id byte may arrive on the closing beat of a three-byte packet
  assign id_value = (wr_pos_q == IdOffset) ? rx_byte_i : packet_id_q;

  // id routing, hid first
  always_comb begin
    id_hit  = 1'b1;
    id_dest = DEST_DROP;
    if (id_value == hid_id_q) begin
      id_dest = DEST_HID;
    end else if (id_value == cdc_id_q) begin
      id_dest = DEST_CDC;
    end else if (id_value == dev_id_q) begin
      id_dest = DEST_DEV;
    end else begin
      id_hit = 1'b0;
    end
  end

  assign raw_pos     = packet_open_q ? wr_pos_q : RawHeader;
  assign raw_pos_inc = raw_pos + 8'd1;
  assign sum_inc     = sum_q + rx_byte_i;
  assign rem_dec     = (bytes_rem_q != 8'd0) ? bytes_rem_q - 8'd1 : bytes_rem_q;

  always_comb begin
    packet_open_d = packet_open_q;
    discard_d     = discard_q;
    bytes_rem_d   = bytes_rem_q;
    sum_d         = sum_q;
    wr_pos_d      = wr_pos_q;
    packet_id_d   = packet_id_q;
    total_len_d   = total_len_q;

    res_d               = res_q;
    res_d.byte_valid    = 1'b0;
    res_d.byte_value    = 8'd0;
    res_d.byte_index    = 8'd0;
    res_d.packet_end    = 1'b0;
    res_d.packet_length = 8'd0;
    res_d.destination   = DEST_DROP;
    res_d.error_code    = ERR_NONE;

    if (command_i) begin
      discard_d = 1'b0;
    end else if (raw_mode_q) begin
      if (!packet_open_q && !buffer_available_i) begin
        res_d.error_code = ERR_NOBUF;
      end else begin
        packet_open_d    = 1'b1;
        res_d.byte_valid = 1'b1;
        res_d.byte_value = rx_byte_i;
        res_d.byte_index = raw_pos;
        wr_pos_d         = raw_pos_inc;
        if (!more_pending_i || ({1'b0, raw_pos_inc} >= RawLimit)) begin
          res_d.packet_end    = 1'b1;
          res_d.packet_length = raw_pos_inc;
          res_d.destination   = DEST_CDC;
          packet_open_d       = 1'b0;
        end
      end
    end else if (discard_q) begin
      // dropped until timeout
    end else if (!packet_open_q) begin
      if (rx_byte_i < MinLength || rx_byte_i > max_length_q) begin
        discard_d        = 1'b1;
        res_d.error_code = ERR_LENGTH;
      end else if (!buffer_available_i) begin
        discard_d        = 1'b1;
        res_d.error_code = ERR_NOBUF;
      end else begin
        packet_open_d    = 1'b1;
        sum_d            = rx_byte_i;
        total_len_d      = rx_byte_i;
        bytes_rem_d      = rx_byte_i - 8'd1;
        wr_pos_d         = 8'd1;
        packet_id_d      = 8'd0;
        res_d.byte_valid = 1'b1;
        res_d.byte_value = rx_byte_i;
      end
    end else begin
      res_d.byte_valid = 1'b1;
      res_d.byte_value = rx_byte_i;
      res_d.byte_index = wr_pos_q;
      packet_id_d = id_value;
      sum_d       = sum_inc;
      wr_pos_d    = wr_pos_q + 8'd1;
      bytes_rem_d = rem_dec;
      if (rem_dec == 8'd0) begin
        res_d.packet_end    = 1'b1;
        res_d.packet_length = total_len_q;
        packet_open_d       = 1'b0;
        if (sum_inc != SumGood) begin
          res_d.error_code = ERR_CHECKSUM;
          if (more_pending_i) begin
            discard_d = 1'b1;
          end
        end else if (total_len_q < MinIdLength) begin
          res_d.error_code = ERR_ID;
        end else if (id_hit) begin
          res_d.destination = id_dest;
        end else begin
          res_d.error_code = ERR_ID;
        end
      end
    end
    res_d.discarding = discard_d;

    if (!in_fire) begin
      packet_open_d = packet_open_q;
      discard_d     = discard_q;
      bytes_rem_d   = bytes_rem_q;
      sum_d         = sum_q;
      wr_pos_d      = wr_pos_q;
      packet_id_d   = packet_id_q;
      total_len_d   = total_len_q;
    end

    if (cfg_we_i && cfg_idx_e'(cfg_index_i) == CFG_RAW_MODE) begin
      packet_open_d = 1'b0;
      discard_d     = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_mode_q    <= 1'b0;
      max_length_q  <= MaxLengthRst;
      hid_id_q      <= HidIdRst;
      cdc_id_q      <= CdcIdRst;
      dev_id_q      <= DevIdRst;
      packet_open_q <= 1'b0;
      discard_q     <= 1'b0;
      bytes_rem_q   <= 8'd0;
      sum_q         <= 8'd0;
      wr_pos_q      <= 8'd0;
      packet_id_q   <= 8'd0;
      total_len_q   <= 8'd0;
      out_valid_q   <= 1'b0;
    end else begin
      raw_mode_q    <= raw_mode_d;
      max_length_q  <= max_length_d;
      hid_id_q      <= hid_id_d;
      cdc_id_q      <= cdc_id_d;
      dev_id_q      <= dev_id_d;
      packet_open_q <= packet_open_d;
      discard_q     <= discard_d;
      bytes_rem_q   <= bytes_rem_d;
      sum_q         <= sum_d;
      wr_pos_q      <= wr_pos_d;
      packet_id_q   <= packet_id_d;
      total_len_q   <= total_len_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign byte_valid_o    = res_q.byte_valid;
  assign byte_value_o    = res_q.byte_value;
  assign byte_index_o    = res_q.byte_index;
  assign packet_end_o    = res_q.packet_end;
  assign packet_length_o = res_q.packet_length;
  assign destination_o   = res_q.destination;
  assign error_code_o    = res_q.error_code;
  assign discarding_o    = res_q.discarding;

endmodule

[rtl/lcpd_checker.sv]
module lcpd_checker
  import lcpd_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic                byte_valid_o,
  input logic [7:0]          byte_value_o,
  input logic [7:0]          byte_index_o,
  input logic                packet_end_o,
  input logic [7:0]          packet_length_o,
  input logic [1:0]          destination_o,
  input logic [2:0]          error_code_o,
  input logic                discarding_o
);

  // result beat only follows an accepted input beat
  a_out_from_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o))
    else $error("result beat without input beat");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !in_ready_o)
    else $error("input taken while result stalled");

  a_idle_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !byte_valid_o) |-> (byte_value_o == 8'd0 && byte_index_o == 8'd0))
    else $error("dropped beat carries byte data");

  a_no_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !packet_end_o)
      |-> (destination_o == DEST_DROP && packet_length_o == 8'd0))
    else $error("routing reported without packet end");

  a_len_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && error_code_o == ERR_LENGTH) |-> (discarding_o && !byte_valid_o))
    else $error("bad length did not start discard");

endmodule

bind length_checksum_packet_deframer lcpd_checker u_lcpd_checker (.*);

[tb/deframer_checker.sv]
`timescale 1ns / 1ps

module deframer_checker
  import lcpd_pkg::*;
#(
  parameter int unsigned RawChunk = RawChunkDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,

  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,

  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic                command_i,
  input  logic [7:0]          rx_byte_i,
  input  logic                more_pending_i,
  input  logic                buffer_available_i,

  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  result_t             result_i,

  output int unsigned         mismatch_count_o,
  output int unsigned         awaited_count_o,
  output int unsigned         packets_closed_o
);

  logic       raw_mode_q;
  logic [7:0] max_len_q;
  logic [7:0] hid_q;
  logic [7:0] cdc_q;
  logic [7:0] dev_q;

  logic       frame_open;
  logic       skip_until_timeout;
  logic [7:0] left_count;
  logic [7:0] byte_sum;
  logic [7:0] wr_pos;
  logic [7:0] frame_id;
  logic [7:0] frame_len;

  result_t     awaited_placements[$];
  int unsigned result_beats;

  function automatic result_t deframe_step(input logic cmd, input logic [7:0] value,
                                           input logic more, input logic avail);
    result_t r;
    r             = '0;
    r.destination = DEST_DROP;
    r.error_code  = ERR_NONE;
    if (cmd) begin
      skip_until_timeout = 1'b0;
    end else if (raw_mode_q) begin
      if (!frame_open && !avail) begin
        r.error_code = ERR_NOBUF;
      end else begin
        if (!frame_open) begin
          frame_open = 1'b1;
          wr_pos     = RawHeader;
        end
        r.byte_valid = 1'b1;
        r.byte_value = value;
        r.byte_index = wr_pos;
        wr_pos       = wr_pos + 8'd1;
        if (!more || 32'(wr_pos) >= RawChunk + 32'(RawHeader)) begin
          r.packet_end    = 1'b1;
          r.packet_length = wr_pos;
          r.destination   = DEST_CDC;
          frame_open      = 1'b0;
        end
      end
    end else if (skip_until_timeout) begin
      // dropped until the next timeout
    end else if (!frame_open) begin
      if (value < MinLength || value > max_len_q) begin
        skip_until_timeout = 1'b1;
        r.error_code       = ERR_LENGTH;
      end else if (!avail) begin
        skip_until_timeout = 1'b1;
        r.error_code       = ERR_NOBUF;
      end else begin
        frame_open   = 1'b1;
        byte_sum     = value;
        frame_len    = value;
        left_count   = value - 8'd1;
        wr_pos       = 8'd1;
        frame_id     = 8'd0;
        r.byte_valid = 1'b1;
        r.byte_value = value;
        r.byte_index = 8'd0;
      end
    end else begin
      r.byte_valid = 1'b1;
      r.byte_value = value;
      r.byte_index = wr_pos;
      if (wr_pos == IdOffset) frame_id = value;
      byte_sum = byte_sum + value;
      wr_pos   = wr_pos + 8'd1;
      if (left_count != 8'd0) left_count = left_count - 8'd1;
      if (left_count == 8'd0) begin
        r.packet_end    = 1'b1;
        r.packet_length = frame_len;
        frame_open      = 1'b0;
        if (byte_sum != SumGood) begin
          r.error_code = ERR_CHECKSUM;
          if (more) skip_until_timeout = 1'b1;
        end else if (frame_len < MinIdLength) begin
          // no id byte in a two-byte packet
          r.error_code = ERR_ID;
        end else if (frame_id == hid_q) begin
          r.destination = DEST_HID;
        end else if (frame_id == cdc_q) begin
          r.destination = DEST_CDC;
        end else if (frame_id == dev_q) begin
          r.destination = DEST_DEV;
        end else begin
          r.error_code = ERR_ID;
        end
      end
    end
    r.discarding = skip_until_timeout;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (mismatch_count_o < 50) begin
      $display("checker: result beat %0d: %s is %0d, expected %0d",
               result_beats, what, got, want);
    end
    mismatch_count_o++;
  endtask

  // Everything is sampled at the falling edge before the rising edge that commits it.
  always @(negedge clk_i) begin : watch
    result_t want;
    if (!rst_ni) begin
      raw_mode_q         = 1'b0;
      max_len_q          = MaxLengthRst;
      hid_q              = HidIdRst;
      cdc_q              = CdcIdRst;
      dev_q              = DevIdRst;
      frame_open         = 1'b0;
      skip_until_timeout = 1'b0;
      left_count         = 8'd0;
      byte_sum           = 8'd0;
      wr_pos             = 8'd0;
      frame_id           = 8'd0;
      frame_len          = 8'd0;
      result_beats       = 0;
      mismatch_count_o   = 0;
      packets_closed_o   = 0;
      awaited_placements.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (awaited_placements.size() == 0) begin
          report_mismatch("unexpected beat, queue depth", 1, 0);
        end else begin
          want = awaited_placements.pop_front();
          if (result_i.byte_valid !== want.byte_valid)
            report_mismatch("byte_valid", result_i.byte_valid, want.byte_valid);
          if (result_i.byte_value !== want.byte_value)
            report_mismatch("byte_value", result_i.byte_value, want.byte_value);
          if (result_i.byte_index !== want.byte_index)
            report_mismatch("byte_index", result_i.byte_index, want.byte_index);
          if (result_i.packet_end !== want.packet_end)
            report_mismatch("packet_end", result_i.packet_end, want.packet_end);
          if (result_i.packet_length !== want.packet_length)
            report_mismatch("packet_length", result_i.packet_length, want.packet_length);
          if (result_i.destination !== want.destination)
            report_mismatch("destination", result_i.destination, want.destination);
          if (result_i.error_code !== want.error_code)
            report_mismatch("error_code", result_i.error_code, want.error_code);
          if (result_i.discarding !== want.discarding)
            report_mismatch("discarding", result_i.discarding, want.discarding);
        end
        result_beats++;
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_RAW_MODE: begin
            raw_mode_q         = cfg_data_i[0];
            frame_open         = 1'b0;
            skip_until_timeout = 1'b0;
          end
          CFG_MAX_LENGTH: max_len_q = cfg_data_i;
          CFG_HID_ID:     hid_q     = cfg_data_i;
          CFG_CDC_ID:     cdc_q     = cfg_data_i;
          CFG_DEV_ID:     dev_q     = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        want = deframe_step(command_i, rx_byte_i, more_pending_i, buffer_available_i);
        if (want.packet_end) packets_closed_o++;
        awaited_placements.push_back(want);
      end
    end
    awaited_count_o = awaited_placements.size();
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import lcpd_pkg::*;

  localparam int unsigned ClkPeriod  = 10;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 300;

  logic                clk_i              = 1'b0;
  logic                rst_ni             = 1'b0;
  logic                cfg_we_i           = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i        = '0;
  logic [CfgDataW-1:0] cfg_data_i         = '0;
  logic                in_valid_i         = 1'b0;
  logic                command_i          = 1'b0;
  logic [7:0]          rx_byte_i          = 8'd0;
  logic                more_pending_i     = 1'b0;
  logic                buffer_available_i = 1'b0;
  logic                out_ready_i        = 1'b0;

  logic       in_ready_o;
  logic       out_valid_o;
  logic       byte_valid_o;
  logic [7:0] byte_value_o;
  logic [7:0] byte_index_o;
  logic       packet_end_o;
  logic [7:0] packet_length_o;
  logic [1:0] destination_o;
  logic [2:0] error_code_o;
  logic       discarding_o;

  int unsigned mismatch_count;
  int unsigned awaited_count;
  int unsigned packets_closed;

  int unsigned src_idle_pct     = 0;
  int unsigned sink_stall_pct   = 0;
  int unsigned hold_requests    = 0;
  int unsigned beats_sent       = 0;
  int unsigned settings_applied = 0;
  int unsigned cycle_count      = 0;
  bit          break_frames     = 1'b0;

  logic [7:0] cur_max_len = MaxLengthRst;
  logic [7:0] cur_hid     = HidIdRst;
  logic [7:0] cur_cdc     = CdcIdRst;
  logic [7:0] cur_dev     = DevIdRst;

  length_checksum_packet_deframer u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .command_i          (command_i),
    .rx_byte_i          (rx_byte_i),
    .more_pending_i     (more_pending_i),
    .buffer_available_i (buffer_available_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .byte_valid_o       (byte_valid_o),
    .byte_value_o       (byte_value_o),
    .byte_index_o       (byte_index_o),
    .packet_end_o       (packet_end_o),
    .packet_length_o    (packet_length_o),
    .destination_o      (destination_o),
    .error_code_o       (error_code_o),
    .discarding_o       (discarding_o)
  );

  deframer_checker u_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_i         (in_ready_o),
    .command_i          (command_i),
    .rx_byte_i          (rx_byte_i),
    .more_pending_i     (more_pending_i),
    .buffer_available_i (buffer_available_i),
    .out_valid_i        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .result_i           ({byte_valid_o, byte_value_o, byte_index_o, packet_end_o,
                          packet_length_o, destination_o, error_code_o, discarding_o}),
    .mismatch_count_o   (mismatch_count),
    .awaited_count_o    (awaited_count),
    .packets_closed_o   (packets_closed)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // Receiver; a pending hold request drops ready for a long, counted stretch.
  initial begin : sink
    int unsigned holds_served;
    int unsigned n;
    holds_served = 0;
    forever begin
      @(posedge clk_i);
      if (hold_requests != holds_served) begin
        holds_served++;
        for (n = 0; n < HoldCycles; n++) begin
          out_ready_i <= 1'b0;
          @(posedge clk_i);
        end
      end else begin
        out_ready_i <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // Called at a rising edge; returns at the edge that accepts the beat.
  task automatic send_event(input logic cmd, input logic [7:0] value, input logic more,
                            input logic avail);
    if ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    in_valid_i         <= 1'b1;
    command_i          <= cmd;
    rx_byte_i          <= value;
    more_pending_i     <= more;
    buffer_available_i <= avail;
    @(negedge clk_i);
    while (!in_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    beats_sent++;
  endtask

  task automatic send_frame(input logic [7:0] len, input logic [7:0] id, input bit corrupt,
                            input logic last_more, input logic len_avail);
    logic [7:0]  sum;
    logic [7:0]  value;
    int unsigned pos;
    sum = len;
    send_event(1'b0, len, 1'b1, len_avail);
    for (pos = 1; pos + 1 < len; pos++) begin
      if (break_frames && $urandom_range(24) == 0) begin
        send_event(1'b1, 8'($urandom), 1'($urandom), 1'($urandom));
      end
      value = (pos == 2) ? id : 8'($urandom);
      sum   = sum + value;
      send_event(1'b0, value, 1'($urandom), 1'($urandom));
    end
    value = SumGood - sum;
    if (corrupt) value = value ^ 8'($urandom_range(255, 1));
    send_event(1'b0, value, last_more, 1'($urandom));
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (awaited_count != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic run_phase(input logic raw, input logic [7:0] max_len, input logic [7:0] hid,
                           input logic [7:0] cdc, input logic [7:0] dev,
                           input int unsigned src_pct, input int unsigned sink_pct,
                           input int unsigned beats, input bit long_hold);
    int unsigned stop_at;
    int unsigned r;
    int unsigned n;
    int unsigned k;
    logic [7:0]  len;
    logic [7:0]  id;
    logic [7:0]  value;
    settle();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_RAW_MODE;
    cfg_data_i  <= {7'd0, raw};
    @(posedge clk_i);
    cfg_index_i <= CFG_MAX_LENGTH;
    cfg_data_i  <= max_len;
    @(posedge clk_i);
    cfg_index_i <= CFG_HID_ID;
    cfg_data_i  <= hid;
    @(posedge clk_i);
    cfg_index_i <= CFG_CDC_ID;
    cfg_data_i  <= cdc;
    @(posedge clk_i);
    cfg_index_i <= CFG_DEV_ID;
    cfg_data_i  <= dev;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_max_len = max_len;
    cur_hid     = hid;
    cur_cdc     = cdc;
    cur_dev     = dev;
    settings_applied++;
    src_idle_pct = src_pct;
    sink_stall_pct <= sink_pct;
    if (long_hold) hold_requests <= hold_requests + 1;

    stop_at = beats_sent + beats;
    while (beats_sent < stop_at) begin
      r = $urandom_range(99);
      if (raw) begin
        if (r < 8) begin
          send_event(1'b1, 8'($urandom), 1'($urandom), 1'($urandom));
        end else begin
          // long bursts can cross the chunk limit, short ones close on more_pending
          n = (r < 20) ? $urandom_range(140, 60) : $urandom_range(20, 1);
          for (k = 0; k < n; k++) begin
            send_event(1'b0, 8'($urandom), (k + 1 < n) ^ ($urandom_range(19) == 0),
                       $urandom_range(19) != 0);
          end
        end
      end else if (r < 60 && cur_max_len >= MinLength) begin
        if ($urandom_range(4) < 2) send_event(1'b1, 8'($urandom), 1'($urandom), 1'($urandom));
        if ($urandom_range(9) == 0) begin
          len = 8'($urandom_range(cur_max_len, 2));
        end else begin
          len = 8'(2 + $urandom_range(cur_max_len > 8'd12 ? 10 : cur_max_len - 2));
        end
        case ($urandom_range(3))
          0:       id = cur_hid;
          1:       id = cur_cdc;
          2:       id = cur_dev;
          default: id = 8'($urandom);
        endcase
        send_frame(len, id, $urandom_range(99) < 15, 1'($urandom), $urandom_range(19) != 0);
      end else if (r < 72) begin
        send_event(1'b1, 8'($urandom), 1'($urandom), 1'($urandom));
      end else if (r < 82) begin
        if (cur_max_len == 8'd255 || $urandom_range(1) == 0) begin
          value = 8'($urandom_range(1));
        end else begin
          value = 8'($urandom_range(255, cur_max_len + 1));
        end
        send_event(1'b0, value, 1'($urandom), 1'($urandom));
        if ($urandom_range(9) < 7) send_event(1'b1, 8'($urandom), 1'($urandom), 1'($urandom));
      end else if (r < 88) begin
        value = (cur_max_len >= MinLength) ? 8'($urandom_range(cur_max_len, 2)) : 8'($urandom);
        send_event(1'b0, value, 1'($urandom), 1'b0);
      end else begin
        send_event(1'b0, 8'($urandom), 1'($urandom), 1'($urandom));
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed beats under the reset settings
    send_event(1'b1, 8'h00, 1'b0, 1'b0);
    send_event(1'b0, 8'h00, 1'b1, 1'b1);            // length below two
    send_event(1'b0, 8'hFF, 1'b1, 1'b1);            // dropped while discarding
    send_event(1'b1, 8'hFF, 1'b1, 1'b1);
    send_event(1'b0, MaxLengthRst + 8'd1, 1'b0, 1'b1);
    send_event(1'b1, 8'h5A, 1'b0, 1'b1);
    send_event(1'b0, 8'd4, 1'b1, 1'b0);             // no buffer
    send_event(1'b1, 8'hA5, 1'b1, 1'b0);
    send_frame(8'd4, DevIdRst, 1'b0, 1'b0, 1'b1);
    send_frame(8'd2, 8'h00, 1'b0, 1'b0, 1'b1);      // two-byte packet, no id
    send_frame(8'd5, HidIdRst, 1'b1, 1'b1, 1'b1);   // bad sum, more pending
    send_event(1'b1, 8'h00, 1'b0, 1'b1);
    send_frame(8'd4, 8'hFF, 1'b0, 1'b1, 1'b1);      // unknown id
    break_frames = 1'b1;

    run_phase(1'b0, 8'd67,  8'd1, 8'd2,   8'd3,   0,  0,  100, 1'b0);
    run_phase(1'b0, 8'd255, 8'd0, 8'd255, 8'd128, 45, 0,  100, 1'b0);
    run_phase(1'b0, 8'd2,   8'd9, 8'd10,  8'd11,  0,  45, 60,  1'b0);
    run_phase(1'b1, 8'd67,  8'd1, 8'd2,   8'd3,   20, 20, 110, 1'b1);
    run_phase(1'b0, 8'd1,   8'd1, 8'd2,   8'd3,   45, 0,  40,  1'b0);
    run_phase(1'b0, 8'd20,  8'd7, 8'd7,   8'd7,   0,  0,  100, 1'b0);
    run_phase(1'b1, 8'd255, 8'd0, 8'd0,   8'd0,   45, 0,  100, 1'b0);
    run_phase(1'b0, 8'd67,  8'd1, 8'd2,   8'd3,   20, 20, 120, 1'b1);
    settle();

    $display("testbench: %0d input beats under %0d register settings, %0d packets closed",
             beats_sent, settings_applied + 1, packets_closed);
    if (mismatch_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

[files.f]
rtl/lcpd_pkg.sv
rtl/length_checksum_packet_deframer.sv
rtl/lcpd_checker.sv
tb/deframer_checker.sv
tb/testbench.sv
